@@ sv/mvavg_pkg.sv @@
// Shared constants and types of the moving-average filter.
package mvavg_pkg;

    localparam int CFG_W    = 7;
    localparam int WL_RESET = 16;

    typedef struct packed {
        logic busy;
        logic done;
    } mvavg_div_stat_t;

endpackage

@@ sv/mvavg_store.sv @@
// Sample ring store: one write port and one registered read port.
module mvavg_store
    import mvavg_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mvavg_div.sv @@
// Restoring unsigned divider that resolves one quotient bit per cycle.
module mvavg_div
    import mvavg_pkg::*;
#(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output mvavg_div_stat_t  stat,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb begin
        rem_sh = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        fits   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CW'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff : rem_sh;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quo       = num_reg;

endmodule

@@ sv/moving_average_filter.sv @@
// Top level of the moving-average filter: sequencer, running sum and result register.
// A sample transfer is averaged over the last window_length samples held in a ring
// store; the result is the running sum divided by the number of samples held, truncated
// toward zero. A sample passes the update, divider start, divider wait and done states
// before its result is offered; the restoring divider resolves one quotient bit per
// cycle while the sequencer waits. A clear transfer goes from idle straight to the done
// state, and the block takes the next item once it is back in idle.
// One item is in work at a time, and the next may be taken while the previous result
// still waits; a finished result that finds the output register still full holds the
// block until that transfer completes. A write on the configuration channel sets the
// window length (0 reads as 1, values above DEPTH as DEPTH) and empties the filter; the
// channel is ready only while no item is in work, and it takes precedence over a sample.
module moving_average_filter
    import mvavg_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // sample
    input  logic                                 s_tuser,  // clear
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,  // average
    output logic                                 m_tuser,  // window_full
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_W-1:0]                     cfg_data  // window_length
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = SAMPLE_WIDTH + AW;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int WL_INIT = (WL_RESET > DEPTH) ? DEPTH : WL_RESET;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_DIVS = 3'd2;
    localparam logic [2:0] ST_DIVW = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               window_reg, window_next;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SAMPLE_WIDTH-1:0]        res_avg_reg, res_avg_next;
    logic                           res_full_reg, res_full_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]             m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg, m_tuser_next;

    logic                           s_accept;
    logic                           cfg_accept;
    logic [CNT_W-1:0]               wl_sat;
    logic [SAMPLE_WIDTH-1:0]        store_rdata;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic signed [SAMPLE_WIDTH:0]   delta;
    logic [CNT_W:0]                 pos_inc;
    logic                           store_we;
    logic                           div_start;
    logic [SUM_W-1:0]               sum_abs;
    logic [SUM_W-1:0]               div_quo;
    logic [SUM_W-1:0]               avg_signed;
    mvavg_div_stat_t                div_stat;

    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign store_we   = (state_reg == ST_UPD);
    assign div_start  = (state_reg == ST_DIVS);

    always_comb begin
        if (cfg_data == '0) begin
            wl_sat = CNT_W'(1);
        end else if (CMP_W'(cfg_data) > CMP_W'(DEPTH)) begin
            wl_sat = CNT_W'(DEPTH);
        end else begin
            wl_sat = CNT_W'(cfg_data);
        end
    end

    mvavg_store #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .re    (s_accept),
        .raddr (pos_reg),
        .rdata (store_rdata)
    );

    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    mvavg_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_abs),
        .den     (fill_reg),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    assign avg_signed = sum_reg[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;

    always_comb begin
        old_sample = (fill_reg < window_reg) ? '0 : $signed(store_rdata);
        delta      = (SAMPLE_WIDTH+1)'(sample_reg) - (SAMPLE_WIDTH+1)'(old_sample);
        pos_inc    = (CNT_W+1)'(pos_reg) + 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        window_next   = window_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        res_avg_next  = res_avg_reg;
        res_full_next = res_full_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        fill_next     = '0;
                        pos_next      = '0;
                        sum_next      = '0;
                        res_avg_next  = '0;
                        res_full_next = 1'b0;
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                sum_next = sum_reg + SUM_W'(delta);
                pos_next = (pos_inc >= (CNT_W+1)'(window_reg)) ? '0 : pos_inc[AW-1:0];
                if (fill_reg < window_reg) begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_stat.done) begin
                    res_avg_next  = avg_signed[SAMPLE_WIDTH-1:0];
                    res_full_next = (fill_reg == window_reg);
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'(res_avg_reg);
                    m_tuser_next  = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_accept) begin
            window_next = wl_sat;
            fill_next   = '0;
            pos_next    = '0;
            sum_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            window_reg   <= CNT_W'(WL_INIT);
            fill_reg     <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        res_avg_reg  <= res_avg_next;
        res_full_reg <= res_full_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= window_reg)
        else $error("Fill count exceeds the window length.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W+1)'(pos_reg) < (CNT_W+1)'(window_reg))
        else $error("Write position lies outside the window.");
    assert property (@(posedge aclk) disable iff (!aresetn) div_start |-> !div_stat.busy)
        else $error("Divider started while busy.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIVW)
        else $error("Divider finished outside the wait state.");
`endif

endmodule

@@ tb/mvavg_checker.sv @@
// Checker for the moving-average filter: watches every channel, predicts each average and compares.
module mvavg_checker
    import mvavg_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // sample
    input  logic                                 s_tuser,  // clear
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,  // average
    input  logic                                 m_tuser,  // window_full
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [CFG_W-1:0]                     cfg_data, // window_length
    output int                                   pending,
    output int                                   mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] average;
        logic                           window_full;
    } filter_out_t;

    logic signed [SAMPLE_WIDTH-1:0] ring [DEPTH];
    longint                         window_sum;
    int                             write_idx;
    int                             held;
    int                             win_len = WL_RESET;
    int                             fail_tally;
    filter_out_t                    averages_due [$];

    function automatic void empty_window();
        for (int i = 0; i < DEPTH; i++) ring[i] = '0;
        window_sum = 0;
        write_idx  = 0;
        held       = 0;
    endfunction

    function automatic void set_window(logic [CFG_W-1:0] value);
        if (value == 0) begin
            win_len = 1;
        end else if (value > DEPTH) begin
            win_len = DEPTH;
        end else begin
            win_len = value;
        end
        empty_window();
    endfunction

    function automatic filter_out_t average_step(logic signed [SAMPLE_WIDTH-1:0] smp);
        filter_out_t res;
        int          slot;
        longint      quot;
        slot       = (write_idx >= win_len) ? 0 : write_idx;
        window_sum = window_sum - ring[slot] + smp;
        ring[slot] = smp;
        write_idx  = (slot + 1 >= win_len) ? 0 : slot + 1;
        if (held < win_len) held++;
        quot            = window_sum / held;
        res.average     = quot[SAMPLE_WIDTH-1:0];
        res.window_full = (held == win_len);
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        filter_out_t got;
        filter_out_t want;
        if (!aresetn) begin
            win_len = (WL_RESET > DEPTH) ? DEPTH : WL_RESET;
            empty_window();
            averages_due.delete();
        end else begin
            // Results are matched before the new sample is predicted, so an unexpected
            // result can never pair with an average due from the same edge.
            if (m_tvalid && m_tready) begin
                got.average     = m_tdata[SAMPLE_WIDTH-1:0];
                got.window_full = m_tuser;
                if (averages_due.size() == 0) begin
                    $error("unexpected result transfer: average %0d, window_full %0b",
                           got.average, got.window_full);
                    fail_tally++;
                end else begin
                    want = averages_due.pop_front();
                    if (got.average !== want.average) begin
                        $error("average: expected %0d, actual %0d", want.average, got.average);
                        fail_tally++;
                    end
                    if (got.window_full !== want.window_full) begin
                        $error("window_full: expected %0b, actual %0b",
                               want.window_full, got.window_full);
                        fail_tally++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                set_window(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    empty_window();
                    averages_due.push_back('0);
                end else begin
                    averages_due.push_back(average_step(s_tdata[SAMPLE_WIDTH-1:0]));
                end
            end
        end
        pending    <= averages_due.size();
        mismatches <= fail_tally;
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the moving-average filter testbench: clock, reset, stimulus, receiver and verdict.
module tb_top
    import mvavg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 64;
    localparam int SW             = 16;
    localparam int DW             = ((SW + 7) / 8) * 8;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 73;
    localparam int HOLD_CYCLES    = 500;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [DW-1:0]    s_tdata   = '0;   // sample
    logic             s_tuser   = 1'b0; // clear
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [DW-1:0]    m_tdata;          // average
    logic             m_tuser;          // window_full
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;   // window_length

    int pending;
    int mismatches;
    int quiet_cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    moving_average_filter #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mvavg_checker #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SW)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    function automatic int idle_gap(bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic send_item(logic [DW-1:0] smp, logic clr);
        int gap;
        gap = idle_gap(tx_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= clr;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_window(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int span;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                span = rx_idle_on ? $urandom_range(1, 12) : 1;
                repeat (span) @(posedge aclk);
                span = idle_gap(rx_idle_on);
                if (span > 0) begin
                    m_tready <= 1'b0;
                    repeat (span) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [DW-1:0]    smp;
        logic [CFG_W-1:0] wl;
        int               roll;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Default window straight after reset, then the zero and oversized window writes.
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0001, 1'b0);
        write_window(7'd0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b1);
        write_window(7'd127);
        repeat (4) send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b1);
        send_item(16'h3039, 1'b0);
        write_window(7'd65);
        send_item(16'h0064, 1'b0);
        send_item(16'hFF9C, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            roll = $urandom_range(0, 99);
            case (ph)
                0: wl = 7'd64;
                1: wl = 7'd1;
                2: wl = 7'd3;
                default: begin
                    if (roll < 50) begin
                        wl = CFG_W'($urandom_range(2, 12));
                    end else if (roll < 85) begin
                        wl = CFG_W'($urandom_range(13, 64));
                    end else if (roll < 95) begin
                        wl = CFG_W'($urandom_range(65, 127));
                    end else begin
                        wl = 7'd0;
                    end
                end
            endcase
            write_window(wl);
            tx_idle_on = (ph % 3 != 0);
            rx_idle_on = (ph % 4 != 1);
            // The receiver holds off while samples keep coming, so the input backs up.
            if (ph == 2) begin
                tx_idle_on   = 1'b0;
                hold_request = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0:       smp = 16'h7FFF;
                    1:       smp = 16'h8000;
                    2, 3:    smp = DW'($urandom_range(0, 31) - 16);
                    default: smp = DW'($urandom);
                endcase
                send_item(smp, $urandom_range(0, 59) == 0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
